// File: sv/timed_batch_sequencer_defines.svh
// Assertion macros shared by the timed batch sequencer RTL.
`ifndef TIMED_BATCH_SEQUENCER_DEFINES_SVH
`define TIMED_BATCH_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TBS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbs assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define TBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbs assertion failed");

`endif

// File: sv/tbs_pkg.sv
// Package: constants and types for the timed batch sequencer.
package tbs_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TICKS_PER_SECOND = 2'd0,
    CFG_PRODUCTION_HOURS = 2'd1,
    CFG_SETTLE_MINUTES   = 2'd2,
    CFG_VALVE_MINUTES    = 2'd3
  } cfg_idx_e;

  // Reported process status
  typedef enum logic [1:0] {
    ST_INITIAL   = 2'd0,
    ST_PRODUCING = 2'd1,
    ST_DONE      = 2'd2,
    ST_SETTLING  = 2'd3
  } status_e;

  localparam int unsigned CfgDataWidth = 8;

  // Reset values of the configuration registers
  localparam logic [7:0] TicksPerSecondRst  = 8'd125;
  localparam logic [3:0] ProductionHoursRst = 4'd2;
  localparam logic [5:0] SettleMinutesRst   = 6'd10;
  localparam logic [5:0] ValveMinutesRst    = 6'd10;

  // Cascade point for seconds and minutes
  localparam logic [5:0] SixtyCount = 6'd60;

  typedef logic [CfgDataWidth-1:0] cfg_data_t;

endpackage

// File: sv/tbs_in_if.sv
// Interface: input channel carrying one tick/level sample per transaction.
interface tbs_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic liquid_present;

  modport source (output valid, output tick, output liquid_present, input ready);
  modport sink   (input valid, input tick, input liquid_present, output ready);
endinterface

// File: sv/tbs_out_if.sv
// Interface: result channel carrying the drive levels and status per transaction.
interface tbs_out_if;
  logic valid;
  logic ready;
  logic producer_on;
  logic valve_on;
  logic batch_ready;
  logic [1:0] process_status;

  modport source (output valid, output producer_on, output valve_on, output batch_ready,
                  output process_status, input ready);
  modport sink   (input valid, input producer_on, input valve_on, input batch_ready,
                  input process_status, output ready);
endinterface

// File: sv/timed_batch_sequencer.sv
// Top level: timed batch sequencer (production, settling, valve phases).
//
// Usage:
//   in_i  carries one sample per transaction: a base-tick flag and the tank
//         level flag. Each accepted transaction advances the sequencer once.
//   out_o returns exactly one result per input transaction: producer drive,
//         valve drive, batch-ready flag and a 2-bit process status.
//   cfg_* writes one of four registers (ticks per second, production hours,
//         settle minutes, valve minutes) on any clock with cfg_we_i high;
//         write only while no transaction is in flight.
// Result: the result of a transaction is registered and is on out_o in the
//   cycle after it is accepted. Throughput: one transaction per cycle while
//   out_o.ready is high; the whole step is a short counter/compare path from
//   the state registers into the result register.
// Stall: the single result register holds while out_o.ready is low; in_i.ready
//   is low only while that register is full and not being drained.
// Reset: rst_ni (async, active low) clears all timers and flags, empties the
//   result register and loads the configuration defaults (125, 2, 10, 10).

`include "timed_batch_sequencer_defines.svh"

module timed_batch_sequencer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tbs_in_if.sink                   in_i,
  tbs_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  tbs_pkg::cfg_idx_e        cfg_idx_i,
  input  tbs_pkg::cfg_data_t       cfg_data_i
);

  // Configuration registers
  logic [7:0] tps_q;
  logic [3:0] prod_hours_cfg_q;
  logic [5:0] settle_min_cfg_q;
  logic [5:0] valve_min_cfg_q;

  // Sequencer state
  logic [7:0] psc_q, psc_d;
  logic [5:0] prod_sec_q, prod_sec_d;
  logic [5:0] prod_min_q, prod_min_d;
  logic [3:0] prod_hr_q, prod_hr_d;
  logic [5:0] set_sec_q, set_sec_d;
  logic [5:0] set_min_q, set_min_d;
  logic [5:0] vlv_sec_q, vlv_sec_d;
  logic [5:0] vlv_min_q, vlv_min_d;
  logic producing_q, producing_d;
  logic settling_q, settling_d;
  logic set_req_q, set_req_d;
  logic set_done_q, set_done_d;
  logic valve_act_q, valve_act_d;
  logic water_rdy_q, water_rdy_d;
  tbs_pkg::status_e status_q, status_d;

  // Result register
  logic out_valid_q;
  logic in_accept;
  logic sec_step;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q            <= tbs_pkg::TicksPerSecondRst;
      prod_hours_cfg_q <= tbs_pkg::ProductionHoursRst;
      settle_min_cfg_q <= tbs_pkg::SettleMinutesRst;
      valve_min_cfg_q  <= tbs_pkg::ValveMinutesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbs_pkg::CFG_TICKS_PER_SECOND: tps_q            <= cfg_data_i[7:0];
        tbs_pkg::CFG_PRODUCTION_HOURS: prod_hours_cfg_q <= cfg_data_i[3:0];
        tbs_pkg::CFG_SETTLE_MINUTES:   settle_min_cfg_q <= cfg_data_i[5:0];
        tbs_pkg::CFG_VALVE_MINUTES:    valve_min_cfg_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // One sequencer step, comparisons in fixed order
  always_comb begin
    psc_d       = psc_q;
    prod_sec_d  = prod_sec_q;
    prod_min_d  = prod_min_q;
    prod_hr_d   = prod_hr_q;
    set_sec_d   = set_sec_q;
    set_min_d   = set_min_q;
    vlv_sec_d   = vlv_sec_q;
    vlv_min_d   = vlv_min_q;
    producing_d = producing_q;
    settling_d  = settling_q;
    set_req_d   = set_req_q;
    set_done_d  = set_done_q;
    valve_act_d = valve_act_q;
    water_rdy_d = water_rdy_q;
    status_d    = status_q;

    // prescaler, saturating
    if (in_i.tick && psc_q != 8'hFF) begin
      psc_d = psc_q + 8'd1;
    end
    sec_step = (psc_d >= tps_q);

    // second steps for active phases
    if (sec_step) begin
      if (producing_q) begin
        if (prod_sec_d != 6'd63) prod_sec_d = prod_sec_d + 6'd1;
        psc_d = '0;
      end
      if (valve_act_q) begin
        if (vlv_sec_d != 6'd63) vlv_sec_d = vlv_sec_d + 6'd1;
        psc_d = '0;
      end
      if (settling_q) begin
        if (set_sec_d != 6'd63) set_sec_d = set_sec_d + 6'd1;
        psc_d = '0;
      end
    end

    // cascades
    if (prod_sec_d >= tbs_pkg::SixtyCount) begin
      if (prod_min_d != 6'd63) prod_min_d = prod_min_d + 6'd1;
      prod_sec_d = '0;
    end
    if (vlv_sec_d >= tbs_pkg::SixtyCount) begin
      if (vlv_min_d != 6'd63) vlv_min_d = vlv_min_d + 6'd1;
      vlv_sec_d = '0;
    end
    if (set_sec_d >= tbs_pkg::SixtyCount) begin
      if (set_min_d != 6'd63) set_min_d = set_min_d + 6'd1;
      set_sec_d = '0;
    end
    if (prod_min_d >= tbs_pkg::SixtyCount) begin
      if (prod_hr_d != 4'd15) prod_hr_d = prod_hr_d + 4'd1;
      prod_min_d = '0;
    end

    // production end
    if (prod_hr_d >= prod_hours_cfg_q && producing_d) begin
      prod_hr_d   = '0;
      producing_d = 1'b0;
      water_rdy_d = 1'b1;
      set_req_d   = 1'b1;
      status_d    = tbs_pkg::ST_DONE;
    end

    // production start
    if (in_i.liquid_present && !water_rdy_d) begin
      producing_d = 1'b1;
      status_d    = tbs_pkg::ST_PRODUCING;
    end

    // settle end, then settle start
    if (settling_d && set_min_d >= settle_min_cfg_q) begin
      settling_d = 1'b0;
      set_req_d  = 1'b0;
      set_done_d = 1'b1;
      set_min_d  = '0;
    end
    if (set_req_d) begin
      settling_d = 1'b1;
      status_d   = tbs_pkg::ST_SETTLING;
    end

    // valve close, then valve open
    if (vlv_min_d >= valve_min_cfg_q && valve_act_d) begin
      vlv_min_d   = '0;
      status_d    = tbs_pkg::ST_DONE;
      valve_act_d = 1'b0;
      water_rdy_d = 1'b0;
      set_done_d  = 1'b0;
    end
    if (set_done_d) begin
      valve_act_d = 1'b1;
    end
  end

  // State update on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psc_q       <= '0;
      prod_sec_q  <= '0;
      prod_min_q  <= '0;
      prod_hr_q   <= '0;
      set_sec_q   <= '0;
      set_min_q   <= '0;
      vlv_sec_q   <= '0;
      vlv_min_q   <= '0;
      producing_q <= 1'b0;
      settling_q  <= 1'b0;
      set_req_q   <= 1'b0;
      set_done_q  <= 1'b0;
      valve_act_q <= 1'b0;
      water_rdy_q <= 1'b0;
      status_q    <= tbs_pkg::ST_INITIAL;
    end else if (in_accept) begin
      psc_q       <= psc_d;
      prod_sec_q  <= prod_sec_d;
      prod_min_q  <= prod_min_d;
      prod_hr_q   <= prod_hr_d;
      set_sec_q   <= set_sec_d;
      set_min_q   <= set_min_d;
      vlv_sec_q   <= vlv_sec_d;
      vlv_min_q   <= vlv_min_d;
      producing_q <= producing_d;
      settling_q  <= settling_d;
      set_req_q   <= set_req_d;
      set_done_q  <= set_done_d;
      valve_act_q <= valve_act_d;
      water_rdy_q <= water_rdy_d;
      status_q    <= status_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result fields mirror the state registers updated by the last transaction
  assign out_o.valid          = out_valid_q;
  assign out_o.producer_on    = producing_q;
  assign out_o.valve_on       = valve_act_q;
  assign out_o.batch_ready    = water_rdy_q;
  assign out_o.process_status = status_q;

  // Checks
  `TBS_ASSERT_IMPL(a_no_prod_and_valve, 1'b1, !(producing_q && valve_act_q))
  `TBS_ASSERT_IMPL(a_valve_needs_batch, valve_act_q, water_rdy_q)
  `TBS_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_q)

endmodule

// File: sim/testbench.sv
// Testbench: self-checking stimulus and scoreboard for the timed batch sequencer.
`timescale 1ns / 1ps

module testbench;

  // Directed rows: either one sample transaction or one register write
  typedef enum bit {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef enum bit [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    bit               producer_on;
    bit               valve_on;
    bit               batch_ready;
    tbs_pkg::status_e status;
  } seq_out_t;

  typedef struct packed {
    row_kind_e          kind;
    bit                 tick;
    bit                 liquid;
    tbs_pkg::cfg_idx_e  idx;
    tbs_pkg::cfg_data_t data;
    bit                 typed;
    bit                 e_prod;
    bit                 e_valve;
    bit                 e_ready;
    tbs_pkg::status_e   e_status;
  } dir_row_t;

  typedef struct packed {
    tbs_pkg::cfg_data_t tps;
    tbs_pkg::cfg_data_t hours;
    tbs_pkg::cfg_data_t settle;
    tbs_pkg::cfg_data_t valve;
    bit [15:0]          count;
    idle_mode_e         mode;
    bit [6:0]           liquid_pct;
    bit [6:0]           tick_pct;
    bit [15:0]          quiet_lead;
    bit                 squeeze;
  } phase_t;

  localparam int NumDirected = 30;
  localparam int NumPhases   = 7;
  localparam int HoldCycles  = 64;

  // Short names for the table below
  localparam tbs_pkg::cfg_idx_e IdxTps = tbs_pkg::CFG_TICKS_PER_SECOND;
  localparam tbs_pkg::cfg_idx_e IdxHrs = tbs_pkg::CFG_PRODUCTION_HOURS;
  localparam tbs_pkg::cfg_idx_e IdxSet = tbs_pkg::CFG_SETTLE_MINUTES;
  localparam tbs_pkg::cfg_idx_e IdxVlv = tbs_pkg::CFG_VALVE_MINUTES;
  localparam tbs_pkg::status_e  StInit = tbs_pkg::ST_INITIAL;
  localparam tbs_pkg::status_e  StProd = tbs_pkg::ST_PRODUCING;

  // Rows with typed expectations come straight after reset on default settings
  localparam dir_row_t DirectedRows [NumDirected] = '{
    '{ROW_SAMPLE, 1'b0, 1'b0, IdxTps, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b1, 1'b0, IdxTps, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b0, 1'b1, IdxTps, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, StProd},
    '{ROW_SAMPLE, 1'b1, 1'b1, IdxTps, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, StProd},
    // zero rate and zero durations: every phase ends at its first compare
    '{ROW_WRITE,  1'b0, 1'b0, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxHrs, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxSet, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxVlv, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b0, 1'b0, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b1, 1'b1, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b0, 1'b1, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b1, 1'b0, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b0, 1'b1, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    // upper data bits beyond each register width are dropped
    '{ROW_WRITE,  1'b0, 1'b0, IdxTps, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxHrs, 8'hF0, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxSet, 8'hC1, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxVlv, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b1, 1'b0, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b0, 1'b1, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b1, 1'b1, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b1, 1'b0, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b0, 1'b0, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    // all registers at their maximum
    '{ROW_WRITE,  1'b0, 1'b0, IdxTps, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxHrs, 8'h0F, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxSet, 8'h3F, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_WRITE,  1'b0, 1'b0, IdxVlv, 8'h3F, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b1, 1'b1, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b1, 1'b0, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b0, 1'b1, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit},
    '{ROW_SAMPLE, 1'b0, 1'b0, IdxTps, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, StInit}
  };

  // Random phases: tps, hours, settle, valve, samples, idling, liquid %, tick %,
  // leading idle-tank samples, receiver hold-off
  localparam phase_t Phases [NumPhases] = '{
    // fast full batches, no idling
    '{8'd0,   8'd0,   8'd0,  8'd0,  16'd100,  IDLE_NONE, 7'd60, 7'd50, 16'd0,   1'b0},
    // settle and valve minute cascades
    '{8'd0,   8'd0,   8'd1,  8'd1,  16'd130,  IDLE_SEND, 7'd70, 7'd50, 16'd0,   1'b0},
    '{8'd1,   8'd0,   8'd1,  8'd2,  16'd130,  IDLE_RECV, 7'd70, 7'd85, 16'd0,   1'b0},
    // empty tank first, so the prescaler runs into saturation
    '{8'd255, 8'd0,   8'd0,  8'd0,  16'd340,  IDLE_BOTH, 7'd70, 7'd90, 16'd290, 1'b0},
    '{8'd0,   8'd15,  8'd63, 8'd63, 16'd60,   IDLE_NONE, 7'd80, 7'd50, 16'd0,   1'b0},
    // masked hours write: production ends at its first compare
    '{8'd0,   8'hF0,  8'd0,  8'd0,  16'd60,   IDLE_SEND, 7'd90, 7'd50, 16'd0,   1'b0},
    '{8'd2,   8'd0,   8'd1,  8'd1,  16'd280,  IDLE_NONE, 7'd70, 7'd80, 16'd0,   1'b1}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  tbs_pkg::cfg_idx_e  cfg_idx_i;
  tbs_pkg::cfg_data_t cfg_data_i;

  tbs_in_if  in_ch ();
  tbs_out_if out_ch ();

  timed_batch_sequencer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Register mirror
  bit [7:0] tps_cfg        = tbs_pkg::TicksPerSecondRst;
  bit [3:0] prod_hours_cfg = tbs_pkg::ProductionHoursRst;
  bit [5:0] settle_min_cfg = tbs_pkg::SettleMinutesRst;
  bit [5:0] valve_min_cfg  = tbs_pkg::ValveMinutesRst;

  // Sequencer state as the predictor tracks it
  bit [7:0] tick_count;
  bit [5:0] run_sec, run_min, settle_sec, settle_min, valve_sec, valve_min;
  bit [3:0] run_hr;
  bit       producing_q, settling_q, settle_req_q, settle_done_q, valve_open_q, batch_held_q;
  tbs_pkg::status_e status_q = tbs_pkg::ST_INITIAL;

  seq_out_t pending_outputs [$];
  int       mismatch_count;
  int       results_seen;
  int       in_idle_pct;
  int       out_stall_pct;
  int       hold_requests;
  int       holds_served;
  int       hold_left;
  bit       offering;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One step of the sequencer for one sample transaction
  function automatic seq_out_t advance_sequencer(bit tick, bit liquid);
    seq_out_t res;
    if (tick && tick_count != 8'hFF) tick_count++;

    // one-second step for each running phase
    if (tick_count >= tps_cfg) begin
      if (producing_q) begin
        if (run_sec != 6'd63) run_sec++;
        tick_count = '0;
      end
      if (valve_open_q) begin
        if (valve_sec != 6'd63) valve_sec++;
        tick_count = '0;
      end
      if (settling_q) begin
        if (settle_sec != 6'd63) settle_sec++;
        tick_count = '0;
      end
    end

    // cascades, saturating
    if (run_sec >= tbs_pkg::SixtyCount) begin
      if (run_min != 6'd63) run_min++;
      run_sec = '0;
    end
    if (valve_sec >= tbs_pkg::SixtyCount) begin
      if (valve_min != 6'd63) valve_min++;
      valve_sec = '0;
    end
    if (settle_sec >= tbs_pkg::SixtyCount) begin
      if (settle_min != 6'd63) settle_min++;
      settle_sec = '0;
    end
    if (run_min >= tbs_pkg::SixtyCount) begin
      if (run_hr != 4'd15) run_hr++;
      run_min = '0;
    end

    // phase transitions in fixed order
    if (run_hr >= prod_hours_cfg && producing_q) begin
      run_hr = '0;
      producing_q = 1'b0;
      batch_held_q = 1'b1;
      settle_req_q = 1'b1;
      status_q = tbs_pkg::ST_DONE;
    end
    if (liquid && !batch_held_q) begin
      producing_q = 1'b1;
      status_q = tbs_pkg::ST_PRODUCING;
    end
    if (settling_q && settle_min >= settle_min_cfg) begin
      settling_q = 1'b0;
      settle_req_q = 1'b0;
      settle_done_q = 1'b1;
      settle_min = '0;
    end
    if (settle_req_q) begin
      settling_q = 1'b1;
      status_q = tbs_pkg::ST_SETTLING;
    end
    if (valve_min >= valve_min_cfg && valve_open_q) begin
      valve_min = '0;
      status_q = tbs_pkg::ST_DONE;
      valve_open_q = 1'b0;
      batch_held_q = 1'b0;
      settle_done_q = 1'b0;
    end
    if (settle_done_q) valve_open_q = 1'b1;

    res.producer_on = producing_q;
    res.valve_on = valve_open_q;
    res.batch_ready = batch_held_q;
    res.status = status_q;
    return res;
  endfunction

  // Offer one sample, optionally after random gaps, and queue its expected result
  task automatic send_sample(bit t, bit l, bit typed, seq_out_t typed_exp);
    int gaps;
    seq_out_t predicted;
    gaps = 0;
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct && gaps < 40) gaps++;
    if (gaps != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gaps) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick <= t;
    in_ch.liquid_present <= l;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    predicted = advance_sequencer(t, l);
    pending_outputs.push_back(typed ? typed_exp : predicted);
  endtask

  // Stop offering and wait until every queued result has been returned
  task automatic wait_for_outputs();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  // Register write; keep the enable high when another write follows
  task automatic write_register(tbs_pkg::cfg_idx_e idx, tbs_pkg::cfg_data_t value, bit more);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      tbs_pkg::CFG_TICKS_PER_SECOND: tps_cfg = value;
      tbs_pkg::CFG_PRODUCTION_HOURS: prod_hours_cfg = value[3:0];
      tbs_pkg::CFG_SETTLE_MINUTES:   settle_min_cfg = value[5:0];
      tbs_pkg::CFG_VALVE_MINUTES:    valve_min_cfg = value[5:0];
      default: ;
    endcase
    if (!more) cfg_we_i <= 1'b0;
  endtask

  // Result receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Scoreboard: compare each returned transaction with the oldest expectation
  always @(posedge clk_i) begin
    seq_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_outputs.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result %0d arrived with nothing expected", $realtime, results_seen);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_ch.producer_on !== want.producer_on || out_ch.valve_on !== want.valve_on ||
            out_ch.batch_ready !== want.batch_ready || out_ch.process_status !== want.status)
        begin
          if (mismatch_count < 10)
            $display("%0t: result %0d expected %0b%0b%0b/%0d, got %0b%0b%0b/%0d",
                     $realtime, results_seen, want.producer_on, want.valve_on,
                     want.batch_ready, want.status, out_ch.producer_on, out_ch.valve_on,
                     out_ch.batch_ready, out_ch.process_status);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    dir_row_t row;
    phase_t   ph;
    seq_out_t typed_exp;
    bit       t;
    bit       l;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tbs_pkg::CFG_TICKS_PER_SECOND;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.tick = 1'b0;
    in_ch.liquid_present = 1'b0;
    out_ch.ready = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedRows[i];
      if (row.kind == ROW_WRITE) begin
        if (i == 0 || DirectedRows[i-1].kind != ROW_WRITE) wait_for_outputs();
        write_register(row.idx, row.data,
                       i + 1 < NumDirected && DirectedRows[i+1].kind == ROW_WRITE);
      end else begin
        typed_exp = '{row.e_prod, row.e_valve, row.e_ready, row.e_status};
        send_sample(row.tick, row.liquid, row.typed, typed_exp);
      end
    end

    // random phases
    for (int p = 0; p < NumPhases; p++) begin
      ph = Phases[p];
      wait_for_outputs();
      write_register(tbs_pkg::CFG_TICKS_PER_SECOND, ph.tps, 1'b1);
      write_register(tbs_pkg::CFG_PRODUCTION_HOURS, ph.hours, 1'b1);
      write_register(tbs_pkg::CFG_SETTLE_MINUTES, ph.settle, 1'b1);
      write_register(tbs_pkg::CFG_VALVE_MINUTES, ph.valve, 1'b0);
      case (ph.mode)
        IDLE_SEND: begin in_idle_pct = 75; out_stall_pct = 0;  end
        IDLE_RECV: begin in_idle_pct = 0;  out_stall_pct = 75; end
        IDLE_BOTH: begin in_idle_pct = 38; out_stall_pct = 38; end
        default:   begin in_idle_pct = 0;  out_stall_pct = 0;  end
      endcase
      for (int n = 0; n < ph.count; n++) begin
        if (n < ph.quiet_lead) begin
          t = 1'b1;
          l = 1'b0;
        end else begin
          t = ($urandom_range(99) < ph.tick_pct);
          l = ($urandom_range(99) < ph.liquid_pct);
        end
        // long receiver hold-off while samples keep coming, later a full drain
        if (ph.squeeze && n == 60) hold_requests++;
        if (ph.squeeze && n == 200) wait_for_outputs();
        send_sample(t, l, 1'b0, '0);
      end
    end

    wait_for_outputs();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_outputs.size() == 0) begin
      $display("timed_batch_sequencer verification clean");
    end else begin
      $display("timed_batch_sequencer verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5ms;
    $display("timed_batch_sequencer verification failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/tbs_pkg.sv
sv/tbs_in_if.sv
sv/tbs_out_if.sv
sv/timed_batch_sequencer.sv
sim/testbench.sv
